// ===== design/bbr_pkg.sv =====
package bbr_pkg;

    // Fixed field widths
    localparam int CHAN_BITS         = 8;
    localparam int PIXEL_BITS        = 3 * CHAN_BITS;
    localparam int IMAGE_WIDTH_BITS  = 11;
    localparam int IMAGE_HEIGHT_BITS = 13;
    localparam int CFG_DATA_BITS     = 13;
    localparam int CFG_INDEX_BITS    = 2;

    // Input row counter runs to height+1 during the drain phase
    localparam int ROW_BITS     = 13;
    // Output row counter runs to height-1
    localparam int OUT_ROW_BITS = 12;

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int IMAGE_WIDTH_RESET  = 640;
    localparam int IMAGE_HEIGHT_RESET = 480;
    localparam int HEIGHT_LIMIT       = 4096;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Position of the output pixel inside the frame
    typedef struct packed {
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
        logic frame_end;
    } pos_t;

    // 3x3 window, [column left..right][row upper..lower]
    typedef logic [2:0][2:0][PIXEL_BITS-1:0] window_t;

endpackage

// ===== design/bbr_ram.sv =====
module bbr_ram
    import bbr_pkg::*;
#(
    parameter int WIDTH = PIXEL_BITS,
    parameter int DEPTH = DEFAULT_MAX_WIDTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bbr_ctrl.sv =====
module bbr_ctrl
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      accept,
    input  logic                      adv,
    input  logic                      command,
    input  logic [CHAN_BITS-1:0]      blue_in,
    input  logic [CHAN_BITS-1:0]      green_in,
    input  logic [CHAN_BITS-1:0]      red_in,
    output logic                      rd_en,
    output logic [CW-1:0]             rd_addr,
    output logic                      s1_valid,
    output logic                      s1_has_result,
    output logic [PIXEL_BITS-1:0]     s1_pix,
    output logic [CW-1:0]             s1_col,
    output pos_t                      s1_pos,
    output logic [CW-1:0]             col_pos,
    output logic [ROW_BITS-1:0]       row_pos,
    output logic [WW-1:0]             w_eff,
    output logic [IMAGE_HEIGHT_BITS-1:0] h_eff
);

    localparam int CMPW    = (WW > IMAGE_WIDTH_BITS) ? WW : IMAGE_WIDTH_BITS;
    localparam int W_RESET = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;

    logic [WW-1:0]                w_eff_reg, w_eff_next;
    logic [IMAGE_HEIGHT_BITS-1:0] h_eff_reg, h_eff_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [ROW_BITS-1:0]          row_reg, row_next;
    logic [CW-1:0]                ox_reg, ox_next;
    logic [OUT_ROW_BITS-1:0]      oy_reg, oy_next;

    logic                         s1_valid_reg, s1_has_result_reg;
    logic [PIXEL_BITS-1:0]        s1_pix_reg;
    logic [CW-1:0]                s1_col_reg;
    pos_t                         s1_pos_reg;

    logic [CMPW-1:0]              wv;
    logic [IMAGE_HEIGHT_BITS-1:0] hv;
    logic                         cfg_hit;
    logic [CW-1:0]                w_last;
    logic [OUT_ROW_BITS-1:0]      h_last;
    logic                         pix_phase, effective, has_result;
    pos_t                         pos;

    assign w_last = CW'(w_eff_reg - WW'(1));
    assign h_last = OUT_ROW_BITS'(h_eff_reg - IMAGE_HEIGHT_BITS'(1));

    // pixels are taken while input rows remain, drains only after
    assign pix_phase  = (ROW_BITS'(h_eff_reg) > row_reg);
    assign effective  = pix_phase ? (command == CMD_PIXEL) : (command == CMD_DRAIN);
    // first result once W+1 items are in
    assign has_result = (row_reg > ROW_BITS'(1)) ||
                        ((row_reg == ROW_BITS'(1)) && (col_reg != '0));

    always_comb
    begin
        pos.first_col = (ox_reg == '0);
        pos.last_col  = (ox_reg == w_last);
        pos.first_row = (oy_reg == '0);
        pos.last_row  = (oy_reg == h_last);
        pos.frame_end = has_result && pos.last_col && pos.last_row;
    end

    // register writes, clamped on the way in
    assign wv      = CMPW'(cfg_data[IMAGE_WIDTH_BITS-1:0]);
    assign hv      = cfg_data[IMAGE_HEIGHT_BITS-1:0];
    assign cfg_hit = cfg_write &&
                     ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

    always_comb
    begin
        w_eff_next = w_eff_reg;
        h_eff_next = h_eff_reg;
        if (cfg_write && (cfg_index == REG_IMAGE_WIDTH))
        begin
            if (wv < CMPW'(2))
                w_eff_next = WW'(2);
            else if (wv > CMPW'(MAX_WIDTH))
                w_eff_next = WW'(MAX_WIDTH);
            else
                w_eff_next = WW'(wv);
        end
        if (cfg_write && (cfg_index == REG_IMAGE_HEIGHT))
        begin
            if (hv < IMAGE_HEIGHT_BITS'(2))
                h_eff_next = IMAGE_HEIGHT_BITS'(2);
            else if (hv > IMAGE_HEIGHT_BITS'(HEIGHT_LIMIT))
                h_eff_next = IMAGE_HEIGHT_BITS'(HEIGHT_LIMIT);
            else
                h_eff_next = hv;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        if (cfg_hit || (accept && effective && pos.frame_end))
        begin
            col_next = '0;
            row_next = '0;
            ox_next  = '0;
            oy_next  = '0;
        end
        else if (accept && effective)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
            if (has_result)
            begin
                if (pos.last_col)
                begin
                    ox_next = '0;
                    oy_next = oy_reg + OUT_ROW_BITS'(1);
                end
                else
                begin
                    ox_next = ox_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg         <= WW'(W_RESET);
            h_eff_reg         <= IMAGE_HEIGHT_BITS'(IMAGE_HEIGHT_RESET);
            col_reg           <= '0;
            row_reg           <= '0;
            ox_reg            <= '0;
            oy_reg            <= '0;
            s1_valid_reg      <= 1'b0;
            s1_has_result_reg <= 1'b0;
        end
        else
        begin
            w_eff_reg <= w_eff_next;
            h_eff_reg <= h_eff_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            if (adv)
            begin
                s1_valid_reg      <= accept && effective;
                s1_has_result_reg <= has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && effective)
        begin
            s1_pix_reg <= pix_phase ? {red_in, green_in, blue_in} : '0;
            s1_col_reg <= col_reg;
            s1_pos_reg <= pos;
        end
    end

    assign rd_en         = accept && effective;
    assign rd_addr       = col_reg;
    assign s1_valid      = s1_valid_reg;
    assign s1_has_result = s1_has_result_reg;
    assign s1_pix        = s1_pix_reg;
    assign s1_col        = s1_col_reg;
    assign s1_pos        = s1_pos_reg;
    assign col_pos       = col_reg;
    assign row_pos       = row_reg;
    assign w_eff         = w_eff_reg;
    assign h_eff         = h_eff_reg;

endmodule

// ===== design/bbr_window.sv =====
module bbr_window
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  rd_en,
    input  logic [CW-1:0]         rd_addr,
    input  logic                  s1_valid,
    input  logic                  s1_has_result,
    input  logic [PIXEL_BITS-1:0] s1_pix,
    input  logic [CW-1:0]         s1_col,
    input  pos_t                  s1_pos,
    output window_t               win,
    output logic                  s2_valid,
    output pos_t                  s2_pos
);

    logic [PIXEL_BITS-1:0] upper_q, middle_q;
    logic                  shift;
    window_t               win_reg;
    logic                  s2_valid_reg;
    pos_t                  s2_pos_reg;

    assign shift = adv && s1_valid;

    // upper line takes what leaves the middle line, middle takes the new pixel
    bbr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper_line (
        .clk   (clk),
        .we    (shift),
        .waddr (s1_col),
        .wdata (middle_q),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (upper_q)
    );

    bbr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle_line (
        .clk   (clk),
        .we    (shift),
        .waddr (s1_col),
        .wdata (s1_pix),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (middle_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid && s1_has_result;
            if (s1_valid)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= {s1_pix, middle_q, upper_q};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            s2_pos_reg <= s1_pos;
        end
    end

    assign win      = win_reg;
    assign s2_valid = s2_valid_reg;
    assign s2_pos   = s2_pos_reg;

endmodule

// ===== design/bbr_avg.sv =====
module bbr_avg
    import bbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 s2_valid,
    input  window_t              win,
    input  pos_t                 s2_pos,
    output logic                 out_valid,
    output logic [CHAN_BITS-1:0] blue_out,
    output logic [CHAN_BITS-1:0] green_out,
    output logic [CHAN_BITS-1:0] red_out,
    output logic                 frame_last
);

    localparam int SUM_BITS = CHAN_BITS + 4;
    // floor(u/3) = (u*683)>>11 and floor(u/9) = (u*1821)>>14 over the sum range
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    localparam int RECIP9       = 1821;
    localparam int RECIP9_SHIFT = 14;
    localparam int P3_BITS      = SUM_BITS + RECIP3_SHIFT;
    localparam int P9_BITS      = SUM_BITS + 1 + RECIP9_SHIFT;

    logic [2:0][2:0]           keep;
    logic [2:0][CHAN_BITS-1:0] avg;
    logic                      x_edge, y_edge;
    logic                      out_valid_reg, frame_last_reg;
    logic [2:0][CHAN_BITS-1:0] avg_reg;

    assign x_edge = s2_pos.first_col || s2_pos.last_col;
    assign y_edge = s2_pos.first_row || s2_pos.last_row;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                keep[c][r] = !((c == 0 && s2_pos.first_col) || (c == 2 && s2_pos.last_col) ||
                               (r == 0 && s2_pos.first_row) || (r == 2 && s2_pos.last_row));
            end
        end
    end

    // rounded mean: floor((2*sum + n) / (2*n)) for n = 4, 6, 9
    always_comb
    begin
        logic [SUM_BITS-1:0] sum;
        logic [SUM_BITS-1:0] u6;
        logic [SUM_BITS:0]   u9;
        logic [P3_BITS-1:0]  p3;
        logic [P9_BITS-1:0]  p9;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = '0;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (keep[c][r])
                        sum = sum + SUM_BITS'(win[c][r][CHAN_BITS*ch +: CHAN_BITS]);
                end
            end
            u6 = (sum + SUM_BITS'(3)) >> 1;
            u9 = (SUM_BITS+1)'(sum) + (SUM_BITS+1)'(4);
            p3 = P3_BITS'(u6) * P3_BITS'(RECIP3);
            p9 = P9_BITS'(u9) * P9_BITS'(RECIP9);
            case ({x_edge, y_edge})
                2'b11:   avg[ch] = CHAN_BITS'((sum + SUM_BITS'(2)) >> 2);
                2'b10,
                2'b01:   avg[ch] = CHAN_BITS'(p3 >> RECIP3_SHIFT);
                default: avg[ch] = CHAN_BITS'(p9 >> RECIP9_SHIFT);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid)
        begin
            avg_reg        <= avg;
            frame_last_reg <= s2_pos.frame_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign blue_out   = avg_reg[0];
    assign green_out  = avg_reg[1];
    assign red_out    = avg_reg[2];
    assign frame_last = frame_last_reg;

endmodule

// ===== design/box_blur_3x3_rgb_unit.sv =====
// 3x3 box blur over an RGB pixel stream in raster order.
// Input channel (in_valid/in_stall): one word per pixel with command = pixel,
// then width+1 words with command = drain after the frame's width*height
// pixels. A drain word that comes early, or a pixel word in the drain phase,
// is taken and dropped.
// Output channel (out_valid/out_stall): one averaged pixel per word, the mean
// over the in-frame neighbors (4 at corners, 6 on edges, 9 inside), rounded
// half up. The output for pixel p is caused by input word p+width+1;
// frame_last marks the frame's final pixel, and the counters then restart.
// A result passes the input, window and result registers after its word is taken.
// Throughput: 1 word per cycle unless a held result is stalled; the stages are
// input register, window with two line RAMs (one read and one write port each),
// and result register. A stall on the output freezes all three stages together,
// so in_stall follows out_stall while a result is held.
// Reset clears the counters and window and loads 640x480; line RAMs are not
// cleared. A write to image_width or image_height restarts the frame; write
// only while the block is idle.
module box_blur_3x3_rgb_unit
    import bbr_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic [CHAN_BITS-1:0]      blue_in,
    input  logic [CHAN_BITS-1:0]      green_in,
    input  logic [CHAN_BITS-1:0]      red_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CHAN_BITS-1:0]      blue_out,
    output logic [CHAN_BITS-1:0]      green_out,
    output logic [CHAN_BITS-1:0]      red_out,
    output logic                      frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic                         adv;
    logic                         accept;
    logic                         rd_en;
    logic [CW-1:0]                rd_addr;
    logic                         s1_valid, s1_has_result;
    logic [PIXEL_BITS-1:0]        s1_pix;
    logic [CW-1:0]                s1_col;
    pos_t                         s1_pos;
    window_t                      win;
    logic                         s2_valid;
    pos_t                         s2_pos;
    logic [CW-1:0]                col_pos;
    logic [ROW_BITS-1:0]          row_pos;
    logic [WW-1:0]                w_eff;
    logic [IMAGE_HEIGHT_BITS-1:0] h_eff;

    // whole pipeline moves when the result register is empty or being taken
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    bbr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .adv           (adv),
        .command       (command),
        .blue_in       (blue_in),
        .green_in      (green_in),
        .red_in        (red_in),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .s1_valid      (s1_valid),
        .s1_has_result (s1_has_result),
        .s1_pix        (s1_pix),
        .s1_col        (s1_col),
        .s1_pos        (s1_pos),
        .col_pos       (col_pos),
        .row_pos       (row_pos),
        .w_eff         (w_eff),
        .h_eff         (h_eff)
    );

    bbr_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .s1_valid      (s1_valid),
        .s1_has_result (s1_has_result),
        .s1_pix        (s1_pix),
        .s1_col        (s1_col),
        .s1_pos        (s1_pos),
        .win           (win),
        .s2_valid      (s2_valid),
        .s2_pos        (s2_pos)
    );

    bbr_avg u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .s2_valid   (s2_valid),
        .win        (win),
        .s2_pos     (s2_pos),
        .out_valid  (out_valid),
        .blue_out   (blue_out),
        .green_out  (green_out),
        .red_out    (red_out),
        .frame_last (frame_last)
    );

    // column counter wraps before it reaches the width
    assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_pos) < w_eff)
    else $error("column counter out of range");

    // input rows never run past the drain row
    assert property (@(posedge clk) disable iff (!rst_n)
        (ROW_BITS+1)'(row_pos) <= (ROW_BITS+1)'(h_eff) + (ROW_BITS+1)'(1))
    else $error("row counter past drain phase");

    // a held output freezes the inner stages
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_valid) && $stable(s2_valid))
    else $error("pipeline moved under stall");

endmodule

// ===== verif/box_blur_3x3_rgb_unit_tb.sv =====
`timescale 1ns / 100ps

module box_blur_3x3_rgb_unit_tb
    import bbr_pkg::*;
();

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 4;
    localparam int MAX_GAP      = 5;
    // The margin covers dropped words still in the pipe
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_WORDS  = 800;
    localparam int LONG_HOLD     = 250;
    localparam int REPORT_LIMIT  = 10;

    // Indexes past the two registers; a write there must leave the frame alone
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    typedef struct packed {
        logic [CHAN_BITS-1:0] blue;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] red;
        logic                 last;
    } blurred_px_t;

    // Tracks the blur pipeline word by word and holds the blurred pixels
    // still owed by the block.
    class blur_scoreboard;
        int unsigned           frame_w;
        int unsigned           frame_h;
        int unsigned           word_no;
        logic [PIXEL_BITS-1:0] upper_row [DEFAULT_MAX_WIDTH];
        logic [PIXEL_BITS-1:0] middle_row [DEFAULT_MAX_WIDTH];
        // [column left..right][row upper..lower]
        logic [PIXEL_BITS-1:0] win [3][3];
        blurred_px_t           blurred_q [$];
        int unsigned           mismatch_count;

        function new();
            frame_w = IMAGE_WIDTH_RESET;
            frame_h = IMAGE_HEIGHT_RESET;
            mismatch_count = 0;
            foreach (upper_row[i])
            begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            restart();
        endfunction

        function void restart();
            word_no = 0;
            foreach (win[c, k])
                win[c][k] = '0;
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            int unsigned raw;
            if (idx == REG_IMAGE_WIDTH)
            begin
                raw = 32'(data[IMAGE_WIDTH_BITS-1:0]);
                frame_w = (raw < 2) ? 2 : (raw > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : raw;
                restart();
            end
            else if (idx == REG_IMAGE_HEIGHT)
            begin
                raw = 32'(data[IMAGE_HEIGHT_BITS-1:0]);
                frame_h = (raw < 2) ? 2 : (raw > HEIGHT_LIMIT) ? HEIGHT_LIMIT : raw;
                restart();
            end
        endfunction

        // One accepted input word
        function void take_word(logic cmd, logic [PIXEL_BITS-1:0] px);
            int unsigned           pixels, n, xn, p, x, r, cnt;
            int unsigned           sum [3];
            logic [CHAN_BITS-1:0]  avg [3];
            logic [PIXEL_BITS-1:0] fresh;
            blurred_px_t           outp;
            int                    c, k, ch;
            pixels = frame_w * frame_h;
            n = word_no;
            if (n < pixels)
            begin
                if (cmd == CMD_DRAIN)
                    return;     // early drain: dropped
                fresh = px;
            end
            else
            begin
                if (cmd == CMD_PIXEL)
                    return;     // surplus pixel: dropped
                fresh = '0;
            end

            xn = n % frame_w;
            for (c = 0; c < 2; c++)
                for (k = 0; k < 3; k++)
                    win[c][k] = win[c + 1][k];
            win[2][0] = upper_row[xn];
            win[2][1] = middle_row[xn];
            win[2][2] = fresh;
            upper_row[xn] = middle_row[xn];
            middle_row[xn] = fresh;
            word_no = n + 1;

            if (n < frame_w + 1)
                return;         // warm-up

            p = n - frame_w - 1;
            x = p % frame_w;
            r = p / frame_w;
            cnt = 0;
            for (ch = 0; ch < 3; ch++)
                sum[ch] = 0;
            for (c = 0; c < 3; c++)
                for (k = 0; k < 3; k++)
                begin
                    // neighbors outside the frame do not count
                    if ((c == 0 && x == 0) || (c == 2 && x == frame_w - 1) ||
                        (k == 0 && r == 0) || (k == 2 && r == frame_h - 1))
                        continue;
                    cnt++;
                    for (ch = 0; ch < 3; ch++)
                        sum[ch] += 32'(win[c][k][CHAN_BITS*ch +: CHAN_BITS]);
                end
            // round half up
            for (ch = 0; ch < 3; ch++)
                avg[ch] = CHAN_BITS'((2 * sum[ch] + cnt) / (2 * cnt));

            outp.blue  = avg[0];
            outp.green = avg[1];
            outp.red   = avg[2];
            outp.last  = (n == pixels + frame_w);
            if (outp.last)
                restart();
            blurred_q.push_back(outp);
        endfunction

        // One accepted output word
        function void check_result(blurred_px_t got);
            blurred_px_t want;
            if (blurred_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected blurred word: b=%h g=%h r=%h last=%b",
                             got.blue, got.green, got.red, got.last);
                return;
            end
            want = blurred_q.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"blurred word mismatch: exp b=%h g=%h r=%h last=%b, ",
                              "got b=%h g=%h r=%h last=%b"},
                             want.blue, want.green, want.red, want.last,
                             got.blue, got.green, got.red, got.last);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      command;
    logic [CHAN_BITS-1:0]      blue_in;
    logic [CHAN_BITS-1:0]      green_in;
    logic [CHAN_BITS-1:0]      red_in;
    logic                      out_valid;
    logic                      out_stall;
    logic [CHAN_BITS-1:0]      blue_out;
    logic [CHAN_BITS-1:0]      green_out;
    logic [CHAN_BITS-1:0]      red_out;
    logic                      frame_last;

    blur_scoreboard sb;
    int             zero_run [2] = '{0, 0};
    int             hold_off_cycles = 0;
    int unsigned    useful_words = 0;
    int unsigned    cycle_count = 0;

    box_blur_3x3_rgb_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .blue_in    (blue_in),
        .green_in   (green_in),
        .red_in     (red_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .blue_out   (blue_out),
        .green_out  (green_out),
        .red_out    (red_out),
        .frame_last (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("box_blur_3x3_rgb_unit_tb NOT OK");
            $finish;
        end
    end

    // Idle cycles before the next word on one side. Up to MAX_GAP, with
    // occasional runs of back-to-back words.
    function automatic int draw_gap(input int side);
        if (zero_run[side] > 0)
        begin
            zero_run[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            zero_run[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Channels lean on 0 and 255 now and then
    function automatic logic [PIXEL_BITS-1:0] make_pixel();
        logic [PIXEL_BITS-1:0] px;
        int                    ch;
        for (ch = 0; ch < 3; ch++)
            case ($urandom_range(0, 7))
                0:       px[CHAN_BITS*ch +: CHAN_BITS] = '0;
                1:       px[CHAN_BITS*ch +: CHAN_BITS] = '1;
                default: px[CHAN_BITS*ch +: CHAN_BITS] = CHAN_BITS'($urandom_range(0, 255));
            endcase
        return px;
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid
    // stays high into the next call when no gap is drawn.
    task automatic send_word(input logic cmd, input logic [PIXEL_BITS-1:0] px);
        int gap;
        gap = draw_gap(SIDE_SEND);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        blue_in  <= px[7:0];
        green_in <= px[15:8];
        red_in   <= px[23:16];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.take_word(cmd, px);
    endtask

    // Register writes happen only with the block idle
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending, wait for every owed word, then let dropped words clear
    task automatic settle_block();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One frame at the current size: pixels, then width+1 drains. A noisy
    // frame mixes in early drains and surplus pixels, may pause mid-frame
    // for a write to a spare index, and may be cut short.
    task automatic run_frame(input bit noisy, output bit aborted);
        int unsigned w, pixels, total;
        int          stop_at, pause_at, i;
        w = sb.frame_w;
        pixels = w * sb.frame_h;
        total = pixels + w + 1;
        stop_at = -1;
        pause_at = -1;
        if (noisy && $urandom_range(0, 9) == 0)
            stop_at = $urandom_range(1, total - 1);
        if (noisy && $urandom_range(0, 7) == 0)
            pause_at = $urandom_range(1, total - 1);
        aborted = 1'b0;
        for (i = 0; i < total; i++)
        begin
            if (i == stop_at)
            begin
                aborted = 1'b1;
                break;
            end
            if (i == pause_at)
            begin
                // sender waits out every owed word mid-frame
                settle_block();
                write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                               CFG_DATA_BITS'($urandom));
            end
            if (i < pixels)
            begin
                if (noisy && $urandom_range(0, 19) == 0)
                    send_word(CMD_DRAIN, make_pixel());
                send_word(CMD_PIXEL, make_pixel());
            end
            else
            begin
                if (noisy && $urandom_range(0, 9) == 0)
                    send_word(CMD_PIXEL, make_pixel());
                send_word(CMD_DRAIN, make_pixel());
            end
            useful_words++;
        end
    endtask

    // Mostly small frames; some back to back with no rewrite, so the
    // block must restart on its own after frame_last.
    task automatic run_random_frames();
        int unsigned              start, w, h, pick;
        logic [CFG_DATA_BITS-1:0] data;
        bit                       need_restart, aborted;
        start = useful_words;
        need_restart = 1'b1;
        while (useful_words - start < RANDOM_WORDS)
        begin
            if (need_restart || $urandom_range(0, 2) != 0)
            begin
                settle_block();
                pick = $urandom_range(0, 19);
                w = (pick < 15) ? $urandom_range(2, 8) :
                    (pick < 19) ? $urandom_range(9, 40) : $urandom_range(0, 1);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
                // bits above the width field are junk to the block
                data = CFG_DATA_BITS'($urandom);
                data[IMAGE_WIDTH_BITS-1:0] = IMAGE_WIDTH_BITS'(w);
                write_register(REG_IMAGE_WIDTH, data);
                write_register(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
            end
            run_frame(1'b1, aborted);
            need_restart = aborted;
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(SIDE_RECV);
            if (hold_off_cycles > 0)
            begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid === 1'b1 && out_stall === 1'b0));
            sb.check_result({blue_out, green_out, red_out, frame_last});
        end
    end

    initial
    begin : stimulus
        bit aborted;
        sb = new();
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        command   <= CMD_PIXEL;
        blue_in   <= '0;
        green_in  <= '0;
        red_in    <= '0;
        out_stall <= 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 frame, both registers below their floor. Every pixel is a
        // corner; blue sums to 258, a half step that must round up.
        write_register(REG_IMAGE_WIDTH, 13'd1);
        write_register(REG_IMAGE_HEIGHT, 13'd0);
        send_word(CMD_DRAIN, 24'hFFFFFF);   // early drain before any pixel
        send_word(CMD_PIXEL, 24'hFFFFFF);
        send_word(CMD_PIXEL, 24'h000003);
        send_word(CMD_DRAIN, 24'h000000);   // early drain mid-frame
        send_word(CMD_PIXEL, 24'h000000);
        send_word(CMD_PIXEL, 24'h010000);
        send_word(CMD_DRAIN, 24'h000000);
        send_word(CMD_PIXEL, 24'h808080);   // surplus pixel in the drain phase
        send_word(CMD_DRAIN, 24'h000000);
        send_word(CMD_DRAIN, 24'h000000);   // frame_last
        settle_block();

        // 3x3: corners, edges and a full nine-pixel center
        write_register(REG_IMAGE_WIDTH, 13'd3);
        write_register(REG_IMAGE_HEIGHT, 13'd3);
        run_frame(1'b0, aborted);
        settle_block();

        // Wider frame; the sink holds off long here while words keep coming
        write_register(REG_IMAGE_WIDTH, 13'd32);
        write_register(REG_IMAGE_HEIGHT, 13'd4);
        hold_off_cycles = LONG_HOLD;
        run_frame(1'b0, aborted);

        run_random_frames();

        settle_block();
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("box_blur_3x3_rgb_unit_tb OK");
        else
            $display("box_blur_3x3_rgb_unit_tb NOT OK");
        $finish;
    end

endmodule
